// File: rtl/core/id3_pkg.sv
// shared types and constants for the id3 tag frame parser
package id3_pkg;

	localparam int ID3_TEXT_MAX = 255;
	localparam int MAX_RES      = 3;

	typedef enum logic [1:0] {
		KIND_TITLE   = 2'd0,
		KIND_ARTIST  = 2'd1,
		KIND_PICTURE = 2'd2,
		KIND_AUDIO   = 2'd3
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  text_char;
		logic [31:0] picture_offset;
		logic [31:0] picture_size;
		logic [28:0] audio_offset;
		logic        run_last;
	} result_t;

	typedef struct packed {
		logic       valid;
		logic [7:0] data_byte;
		logic       file_start;
		logic       file_end;
	} step_req_t;

	typedef struct packed {
		logic [1:0]         count;
		result_t [MAX_RES-1:0] res;
	} step_out_t;

endpackage

// File: rtl/core/id3_if.sv
// request channel interfaces for file bytes and parse results
interface id3_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       file_start;
	logic       file_end;

	modport source(output valid, data_byte, file_start, file_end, input ready);
	modport sink(input valid, data_byte, file_start, file_end, output ready);
endinterface

interface id3_res_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [7:0]  text_char;
	logic [31:0] picture_offset;
	logic [31:0] picture_size;
	logic [28:0] audio_offset;
	logic        run_last;

	modport source(output valid, kind, text_char, picture_offset, picture_size,
		audio_offset, run_last, input ready);
	modport sink(input valid, kind, text_char, picture_offset, picture_size,
		audio_offset, run_last, output ready);
endinterface

// File: rtl/core/id3_step.sv
// parser state and the per-byte step that yields up to three results
module id3_step import id3_pkg::*; #(
	parameter int TEXT_MAX = ID3_TEXT_MAX
) (
	input  logic      clk,
	input  logic      arst_n,
	input  step_req_t req,
	output step_out_t rsp
);

	localparam int TCW = $clog2(TEXT_MAX + 1);
	localparam logic [TCW-1:0] TC_LIMIT = TCW'(TEXT_MAX);

	localparam logic [7:0]  CH_I       = 8'h49;
	localparam logic [7:0]  CH_D       = 8'h44;
	localparam logic [7:0]  CH_3       = 8'h33;
	localparam logic [31:0] ID_TITLE   = 32'h54495432;
	localparam logic [31:0] ID_ARTIST  = 32'h54504531;
	localparam logic [31:0] ID_PICTURE = 32'h41504943;

	typedef enum logic [2:0] {
		PH_HDR,
		PH_EXT,
		PH_EXTSKIP,
		PH_FHDR,
		PH_ENC,
		PH_BODY,
		PH_PADSKIP,
		PH_DONE
	} phase_t;

	function automatic logic [27:0] syncsafe(input logic [31:0] v);
		return {v[30:24], v[22:16], v[14:8], v[6:0]};
	endfunction

	function automatic result_t mk(input kind_t k, input logic [7:0] c,
		input logic [31:0] po, input logic [31:0] ps, input logic [28:0] ao);
		result_t r;
		r.kind           = k;
		r.text_char      = c;
		r.picture_offset = po;
		r.picture_size   = ps;
		r.audio_offset   = ao;
		r.run_last       = 1'b0;
		return r;
	endfunction

	phase_t          ph_q, ph_d;
	logic [31:0]     pos_q, pos_d;
	logic            v4_q, v4_d;
	logic            ext_q, ext_d;
	logic [28:0]     te_q, te_d;
	logic [31:0]     sb_q, sb_d;
	logic [31:0]     fid_q, fid_d;
	logic [31:0]     bl_q, bl_d;
	logic [TCW-1:0]  tc_q, tc_d;
	logic            ta_q, ta_d;
	logic            tia_q, tia_d;

	logic [31:0]     p, nxt, sz, fsz;
	logic [7:0]      b;
	logic            v4, bnd;
	logic [3:0]      idx;
	logic [1:0]      n;
	result_t [MAX_RES-1:0] rr;
	kind_t           tkind;

	always_comb begin
		b = req.data_byte;
		if (req.file_start) begin
			ph_d = PH_HDR;
			p = '0;
			v4_d = 1'b0;
			ext_d = 1'b0;
			te_d = '0;
			sb_d = '0;
			fid_d = '0;
			bl_d = '0;
			tc_d = '0;
			ta_d = 1'b0;
			tia_d = 1'b0;
		end else begin
			ph_d = ph_q;
			p = pos_q;
			v4_d = v4_q;
			ext_d = ext_q;
			te_d = te_q;
			sb_d = sb_q;
			fid_d = fid_q;
			bl_d = bl_q;
			tc_d = tc_q;
			ta_d = ta_q;
			tia_d = tia_q;
		end
		v4 = v4_d;
		nxt = p + 32'd1;
		bnd = 1'b0;
		n = 2'd0;
		rr = '0;
		sz = '0;
		fsz = '0;
		idx = '0;

		case (ph_d)
			PH_HDR: begin
				if ((p == 32'd0 && b != CH_I) || (p == 32'd1 && b != CH_D) ||
					(p == 32'd2 && b != CH_3)) begin
					rr[n] = mk(KIND_AUDIO, 8'd0, 32'd0, 32'd0, 29'd0);
					n = n + 2'd1;
					ph_d = PH_DONE;
				end else begin
					if (p == 32'd3) v4_d = (b >= 8'd4);
					if (p == 32'd5) ext_d = b[6];
					if (p >= 32'd6) sb_d = {sb_d[23:0], b};
					if (p >= 32'd9) begin
						te_d = 29'd10 + {1'b0, syncsafe(sb_d)};
						if (ext_d) begin
							ph_d = PH_EXT;
							bl_d = 32'd4;
							sb_d = '0;
						end else begin
							bnd = 1'b1;
						end
					end
				end
			end
			PH_EXT: begin
				sb_d = {sb_d[23:0], b};
				bl_d = bl_d - 32'd1;
				if (bl_d == 32'd0) begin
					if (v4) begin
						sz = {4'd0, syncsafe(sb_d)};
						sz = (sz < 32'd4) ? 32'd0 : sz - 32'd4;
					end else begin
						sz = sb_d;
					end
					if (sz == 32'd0) begin
						bnd = 1'b1;
					end else begin
						ph_d = PH_EXTSKIP;
						bl_d = sz;
					end
				end
			end
			PH_EXTSKIP: begin
				bl_d = bl_d - 32'd1;
				if (bl_d == 32'd0) bnd = 1'b1;
			end
			PH_FHDR: begin
				idx = 4'd10 - bl_d[3:0];
				if (idx < 4'd4) fid_d = {fid_d[23:0], b};
				else if (idx < 4'd8) sb_d = {sb_d[23:0], b};
				bl_d = bl_d - 32'd1;
				if (bl_d == 32'd0) begin
					fsz = v4 ? {4'd0, syncsafe(sb_d)} : sb_d;
					if (fid_d[31:24] == 8'd0) begin
						ph_d = PH_PADSKIP;
					end else if (fsz == 32'd0) begin
						bnd = 1'b1;
					end else begin
						ta_d = 1'b0;
						bl_d = fsz;
						if (fid_d == ID_TITLE || fid_d == ID_ARTIST) begin
							tia_d = (fid_d == ID_ARTIST);
							ph_d = PH_ENC;
						end else begin
							if (fid_d == ID_PICTURE) begin
								rr[n] = mk(KIND_PICTURE, 8'd0, nxt, fsz, 29'd0);
								n = n + 2'd1;
							end
							ph_d = PH_BODY;
						end
					end
				end
			end
			PH_ENC: begin
				bl_d = bl_d - 32'd1;
				tc_d = '0;
				ta_d = (b == 8'd0 || b == 8'd3);
				if (bl_d == 32'd0) bnd = 1'b1;
				else ph_d = PH_BODY;
			end
			PH_BODY: begin
				if (ta_d) begin
					if (b != 8'd0) begin
						rr[n] = mk(tia_d ? KIND_ARTIST : KIND_TITLE, b, 32'd0, 32'd0,
							29'd0);
						n = n + 2'd1;
						tc_d = tc_d + 1'b1;
					end
					if (b == 8'd0 || tc_d >= TC_LIMIT) begin
						rr[n] = mk(tia_d ? KIND_ARTIST : KIND_TITLE, 8'd0, 32'd0,
							32'd0, 29'd0);
						n = n + 2'd1;
						ta_d = 1'b0;
					end
				end
				bl_d = bl_d - 32'd1;
				if (bl_d == 32'd0) bnd = 1'b1;
			end
			default: begin
			end
		endcase

		tkind = tia_d ? KIND_ARTIST : KIND_TITLE;

		// frame end closes open text, then the next header or padding
		if (bnd) begin
			if (ta_d) begin
				rr[n] = mk(tkind, 8'd0, 32'd0, 32'd0, 29'd0);
				n = n + 2'd1;
				ta_d = 1'b0;
			end
			if (nxt + 32'd10 <= {3'd0, te_d}) begin
				ph_d = PH_FHDR;
				bl_d = 32'd10;
				fid_d = '0;
				sb_d = '0;
			end else begin
				ph_d = PH_PADSKIP;
			end
		end

		if (ph_d != PH_HDR && ph_d != PH_DONE && nxt == {3'd0, te_d}) begin
			if (ta_d) begin
				rr[n] = mk(tkind, 8'd0, 32'd0, 32'd0, 29'd0);
				n = n + 2'd1;
				ta_d = 1'b0;
			end
			rr[n] = mk(KIND_AUDIO, 8'd0, 32'd0, 32'd0, te_d);
			n = n + 2'd1;
			ph_d = PH_DONE;
		end

		if (req.file_end && ph_d != PH_DONE) begin
			if (ph_d == PH_HDR) begin
				rr[n] = mk(KIND_AUDIO, 8'd0, 32'd0, 32'd0, 29'd0);
				n = n + 2'd1;
			end else begin
				if (ta_d) begin
					rr[n] = mk(tkind, 8'd0, 32'd0, 32'd0, 29'd0);
					n = n + 2'd1;
					ta_d = 1'b0;
				end
				rr[n] = mk(KIND_AUDIO, 8'd0, 32'd0, 32'd0, te_d);
				n = n + 2'd1;
			end
			ph_d = PH_DONE;
		end

		if (ph_d == PH_DONE) ta_d = 1'b0;
		pos_d = nxt;

		for (int i = 0; i < MAX_RES; i++) begin
			rr[i].run_last = (n != 2'd0) && (2'(i) == n - 2'd1);
		end
		rsp.count = req.valid ? n : 2'd0;
		rsp.res = rr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= PH_HDR;
			pos_q <= '0;
			v4_q <= 1'b0;
			ext_q <= 1'b0;
			te_q <= '0;
			sb_q <= '0;
			fid_q <= '0;
			bl_q <= '0;
			tc_q <= '0;
			ta_q <= 1'b0;
			tia_q <= 1'b0;
		end else if (req.valid) begin
			ph_q <= ph_d;
			pos_q <= pos_d;
			v4_q <= v4_d;
			ext_q <= ext_d;
			te_q <= te_d;
			sb_q <= sb_d;
			fid_q <= fid_d;
			bl_q <= bl_d;
			tc_q <= tc_d;
			ta_q <= ta_d;
			tia_q <= tia_d;
		end
	end

endmodule

// File: rtl/core/id3_res_q.sv
// result queue that takes up to three results a cycle and sends one while the receiver is ready
module id3_res_q import id3_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  step_out_t        push,
	output logic             room,
	id3_res_if.source        results
);

	localparam int RQ_DEPTH = 4;
	localparam int RQ_AW    = $clog2(RQ_DEPTH);

	result_t              mem [RQ_DEPTH];
	logic [RQ_AW-1:0]     wp_q, rp_q;
	logic [RQ_AW:0]       count_q;
	logic                 pop;
	result_t              head;

	assign head = mem[rp_q];
	assign pop = results.valid && results.ready;
	assign room = (count_q <= (RQ_AW + 1)'(RQ_DEPTH - MAX_RES));

	assign results.valid          = (count_q != '0);
	assign results.kind           = head.kind;
	assign results.text_char      = head.text_char;
	assign results.picture_offset = head.picture_offset;
	assign results.picture_size   = head.picture_size;
	assign results.audio_offset   = head.audio_offset;
	assign results.run_last       = head.run_last;

	always_ff @(posedge clk) begin
		for (int i = 0; i < MAX_RES; i++) begin
			if (2'(i) < push.count) mem[wp_q + RQ_AW'(i)] <= push.res[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			count_q <= '0;
		end else begin
			wp_q <= wp_q + RQ_AW'(push.count);
			if (pop) rp_q <= rp_q + 1'b1;
			count_q <= count_q + (RQ_AW + 1)'(push.count) - (RQ_AW + 1)'(pop);
		end
	end

endmodule

// File: rtl/core/id3v2_tag_frame_parser_unit.sv
// top level of the id3v2 tag frame parser
//
// bytes: one file byte per request, from offset 0, with file_start on the
// first byte of a file and file_end on its last byte. results: one result per
// request (title or artist text byte, picture payload offset and size, audio
// start offset), with run_last on the final result caused by a byte.
// a byte is held in an input register, then one step updates the parser
// state and pushes its zero to three results into a four-entry queue.
// an accepted byte reaches the result port once the step has pushed its
// results into the queue. throughput: one byte per cycle while the receiver
// takes each result and each byte yields at most one; a byte with two or three
// results holds the input while the queue drains, one result per cycle.
// reset clears the parser to the header phase at offset 0 and empties the
// queue. when the receiver stalls, the queue fills, the input register holds
// its byte and bytes.ready falls; nothing is dropped.
// a file without an id3 header reports audio start 0 at once.
module id3v2_tag_frame_parser_unit import id3_pkg::*; #(
	parameter int TEXT_MAX = ID3_TEXT_MAX
) (
	input  logic       clk,
	input  logic       arst_n,
	id3_byte_if.sink   bytes,
	id3_res_if.source  results
);

	step_req_t req_s1;
	step_req_t step_req;
	step_out_t step_rsp;
	logic      room;
	logic      take;

	assign take = req_s1.valid && room;
	assign bytes.ready = !req_s1.valid || room;

	always_comb begin
		step_req = req_s1;
		step_req.valid = take;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_s1 <= '0;
		end else if (bytes.valid && bytes.ready) begin
			req_s1.valid <= 1'b1;
			req_s1.data_byte <= bytes.data_byte;
			req_s1.file_start <= bytes.file_start;
			req_s1.file_end <= bytes.file_end;
		end else if (take) begin
			req_s1.valid <= 1'b0;
		end
	end

	id3_step #(
		.TEXT_MAX(TEXT_MAX)
	) u_step (
		.clk(clk),
		.arst_n(arst_n),
		.req(step_req),
		.rsp(step_rsp)
	);

	id3_res_q u_res_q (
		.clk(clk),
		.arst_n(arst_n),
		.push(step_rsp),
		.room(room),
		.results(results)
	);

endmodule

// File: rtl/core/id3_chk.sv
// port checker for the id3v2 tag frame parser and its bind
module id3_chk import id3_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        res_valid,
	input logic        res_ready,
	input logic [1:0]  kind,
	input logic [7:0]  text_char,
	input logic [31:0] picture_offset,
	input logic [31:0] picture_size,
	input logic [28:0] audio_offset,
	input logic        run_last
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(kind) &&
		$stable(audio_offset) && $stable(run_last))
		else $error("result dropped while stalled");

	a_audio_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && kind == KIND_AUDIO |-> run_last)
		else $error("audio start not last of its byte");

	a_text_clean: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (kind == KIND_TITLE || kind == KIND_ARTIST) |->
		picture_offset == '0 && picture_size == '0 && audio_offset == '0)
		else $error("text result carries other fields");

	a_pic_clean: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && kind == KIND_PICTURE |-> text_char == '0 &&
		audio_offset == '0 && picture_size != '0)
		else $error("picture result malformed");

endmodule

bind id3v2_tag_frame_parser_unit id3_chk u_chk (
	.clk(clk),
	.arst_n(arst_n),
	.res_valid(results.valid),
	.res_ready(results.ready),
	.kind(results.kind),
	.text_char(results.text_char),
	.picture_offset(results.picture_offset),
	.picture_size(results.picture_size),
	.audio_offset(results.audio_offset),
	.run_last(results.run_last)
);

// File: verif/id3_tb_pkg.sv
// header magic, frame ids and text encodings shared by the parser testbench files
package id3_tb_pkg;

	localparam logic [23:0] TAG_MAGIC  = "ID3";
	localparam logic [31:0] ID_TITLE   = "TIT2";
	localparam logic [31:0] ID_ARTIST  = "TPE1";
	localparam logic [31:0] ID_PICTURE = "APIC";
	localparam logic [7:0]  FLAG_EXT   = 8'h40;
	localparam logic [7:0]  ENC_LATIN1 = 8'd0;
	localparam logic [7:0]  ENC_UTF8   = 8'd3;

endpackage

// File: verif/id3_parse_checker.sv
// tag parse predictor and result scoreboard for the id3v2 tag frame parser
module id3_parse_checker import id3_pkg::*; import id3_tb_pkg::*; #(
	parameter int TEXT_LIMIT = ID3_TEXT_MAX
) (
	input  logic clk,
	input  logic arst_n,
	id3_byte_if  byte_mon,
	id3_res_if   res_mon,
	output int   fail_count,
	output int   pending,
	output int   checked,
	output int   text_seen,
	output int   pictures_seen,
	output int   audio_seen
);

	typedef enum logic [3:0] {
		ST_HDR, ST_EXT, ST_EXTSKIP, ST_FHDR, ST_ENC, ST_BODY, ST_PADSKIP, ST_DONE
	} parse_state_t;

	parse_state_t st;
	logic [31:0]  pos;
	logic [7:0]   ver;
	logic         ext_on;
	logic [31:0]  tag_end;
	logic [31:0]  shreg;
	logic [31:0]  fid;
	logic [31:0]  remain;
	int           txt_count;
	logic         txt_on;
	logic         txt_artist;
	result_t      due_results[$];

	function automatic logic [31:0] unsync(input logic [31:0] v);
		return {4'd0, v[30:24], v[22:16], v[14:8], v[6:0]};
	endfunction

	task automatic clear_parse();
		st = ST_HDR;
		pos = '0;
		ver = '0;
		ext_on = 1'b0;
		tag_end = '0;
		shreg = '0;
		fid = '0;
		remain = '0;
		txt_count = 0;
		txt_on = 1'b0;
		txt_artist = 1'b0;
	endtask

	task automatic emit_result(input kind_t k, input logic [7:0] ch, input logic [31:0] po,
		input logic [31:0] ps, input logic [28:0] ao);
		result_t r;
		r.kind = k;
		r.text_char = ch;
		r.picture_offset = po;
		r.picture_size = ps;
		r.audio_offset = ao;
		r.run_last = 1'b0;
		due_results.push_back(r);
	endtask

	task automatic close_text();
		if (txt_on) begin
			emit_result(txt_artist ? KIND_ARTIST : KIND_TITLE, 8'd0, 32'd0, 32'd0, 29'd0);
			txt_on = 1'b0;
		end
	endtask

	task automatic next_frame_hdr(input logic [31:0] nxt);
		if (nxt + 32'd10 <= tag_end) begin
			st = ST_FHDR;
			remain = 32'd10;
			fid = '0;
			shreg = '0;
		end else begin
			st = ST_PADSKIP;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		logic [31:0] p, fsz, sz, idx;
		logic [7:0]  b;
		logic        v4;
		int          base;
		result_t     last_res, want, got;
		if (!arst_n) begin
			clear_parse();
			due_results.delete();
			fail_count = 0;
			pending = 0;
			checked = 0;
			text_seen = 0;
			pictures_seen = 0;
			audio_seen = 0;
		end else begin
			if (byte_mon.valid && byte_mon.ready) begin
				base = due_results.size();
				b = byte_mon.data_byte;
				if (byte_mon.file_start)
					clear_parse();
				p = pos;
				v4 = ver >= 8'd4;
				case (st)
					ST_HDR: begin
						if (p < 3 && b != TAG_MAGIC[8*(2 - p) +: 8]) begin
							emit_result(KIND_AUDIO, 8'd0, 32'd0, 32'd0, 29'd0);
							st = ST_DONE;
						end else begin
							if (p == 3)
								ver = b;
							if (p == 5)
								ext_on = b[6];
							if (p >= 6)
								shreg = {shreg[23:0], b};
							if (p >= 9) begin
								tag_end = 32'd10 + unsync(shreg);
								if (ext_on) begin
									st = ST_EXT;
									remain = 32'd4;
									shreg = '0;
								end else begin
									next_frame_hdr(p + 32'd1);
								end
							end
						end
					end
					ST_EXT: begin
						shreg = {shreg[23:0], b};
						remain = remain - 32'd1;
						if (remain == 0) begin
							if (v4) begin
								sz = unsync(shreg);
								sz = (sz < 32'd4) ? 32'd0 : sz - 32'd4;
							end else begin
								sz = shreg;
							end
							if (sz == 0) begin
								next_frame_hdr(p + 32'd1);
							end else begin
								st = ST_EXTSKIP;
								remain = sz;
							end
						end
					end
					ST_EXTSKIP: begin
						remain = remain - 32'd1;
						if (remain == 0)
							next_frame_hdr(p + 32'd1);
					end
					ST_FHDR: begin
						idx = 32'd10 - remain;
						if (idx < 4)
							fid = {fid[23:0], b};
						else if (idx < 8)
							shreg = {shreg[23:0], b};
						remain = remain - 32'd1;
						if (remain == 0) begin
							fsz = v4 ? unsync(shreg) : shreg;
							if (fid[31:24] == 8'd0) begin
								st = ST_PADSKIP;
							end else if (fsz == 0) begin
								next_frame_hdr(p + 32'd1);
							end else begin
								txt_on = 1'b0;
								remain = fsz;
								if (fid == ID_TITLE || fid == ID_ARTIST) begin
									txt_artist = fid == ID_ARTIST;
									st = ST_ENC;
								end else begin
									if (fid == ID_PICTURE)
										emit_result(KIND_PICTURE, 8'd0, p + 32'd1, fsz, 29'd0);
									st = ST_BODY;
								end
							end
						end
					end
					ST_ENC: begin
						remain = remain - 32'd1;
						txt_count = 0;
						txt_on = b == ENC_LATIN1 || b == ENC_UTF8;
						if (remain == 0) begin
							close_text();
							next_frame_hdr(p + 32'd1);
						end else begin
							st = ST_BODY;
						end
					end
					ST_BODY: begin
						if (txt_on) begin
							if (b == 8'd0) begin
								close_text();
							end else begin
								emit_result(txt_artist ? KIND_ARTIST : KIND_TITLE, b,
									32'd0, 32'd0, 29'd0);
								txt_count++;
								if (txt_count >= TEXT_LIMIT)
									close_text();
							end
						end
						remain = remain - 32'd1;
						if (remain == 0) begin
							close_text();
							next_frame_hdr(p + 32'd1);
						end
					end
					default: ;
				endcase
				if (st != ST_HDR && st != ST_DONE && p + 32'd1 == tag_end) begin
					close_text();
					emit_result(KIND_AUDIO, 8'd0, 32'd0, 32'd0, tag_end[28:0]);
					st = ST_DONE;
				end
				if (byte_mon.file_end && st != ST_DONE) begin
					if (st == ST_HDR) begin
						emit_result(KIND_AUDIO, 8'd0, 32'd0, 32'd0, 29'd0);
					end else begin
						close_text();
						emit_result(KIND_AUDIO, 8'd0, 32'd0, 32'd0, tag_end[28:0]);
					end
					st = ST_DONE;
				end
				if (st == ST_DONE)
					txt_on = 1'b0;
				pos = p + 32'd1;
				if (due_results.size() > base) begin
					last_res = due_results.pop_back();
					last_res.run_last = 1'b1;
					due_results.push_back(last_res);
				end
			end

			if (res_mon.valid && res_mon.ready) begin
				checked++;
				got.kind = kind_t'(res_mon.kind);
				got.text_char = res_mon.text_char;
				got.picture_offset = res_mon.picture_offset;
				got.picture_size = res_mon.picture_size;
				got.audio_offset = res_mon.audio_offset;
				got.run_last = res_mon.run_last;
				case (got.kind)
					KIND_PICTURE: pictures_seen++;
					KIND_AUDIO:   audio_seen++;
					default:      text_seen++;
				endcase
				if (due_results.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected result: kind %0d char %02h pic %0d/%0d audio %0d last %0b",
							got.kind, got.text_char, got.picture_offset, got.picture_size,
							got.audio_offset, got.run_last);
				end else begin
					want = due_results.pop_front();
					if (got.kind !== want.kind || got.text_char !== want.text_char ||
						got.picture_offset !== want.picture_offset ||
						got.picture_size !== want.picture_size ||
						got.audio_offset !== want.audio_offset ||
						got.run_last !== want.run_last) begin
						fail_count++;
						if (fail_count <= 10) begin
							$display("mismatch at result %0d", checked);
							$display("  expected kind %0d char %02h pic %0d/%0d audio %0d last %0b",
								want.kind, want.text_char, want.picture_offset,
								want.picture_size, want.audio_offset, want.run_last);
							$display("  actual   kind %0d char %02h pic %0d/%0d audio %0d last %0b",
								got.kind, got.text_char, got.picture_offset,
								got.picture_size, got.audio_offset, got.run_last);
						end
					end
				end
			end
			pending = due_results.size();
		end
	end

endmodule

// File: verif/tb.sv
// testbench top for the id3v2 tag frame parser: file stimulus, stalls and verdict
module tb import id3_pkg::*; import id3_tb_pkg::*; ();

	localparam int RANDOM_BYTES = 120;

	logic clk;
	logic arst_n;
	int   send_idle;
	int   take_idle;
	int   fail_count, pending, checked, text_seen, pictures_seen, audio_seen;
	int   files_sent, bytes_sent, directed_bytes;
	logic [7:0] file_q[$];

	id3_byte_if bytes_ch();
	id3_res_if  res_ch();

	id3v2_tag_frame_parser_unit dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.bytes   (bytes_ch),
		.results (res_ch)
	);

	id3_parse_checker chk (
		.clk           (clk),
		.arst_n        (arst_n),
		.byte_mon      (bytes_ch),
		.res_mon       (res_ch),
		.fail_count    (fail_count),
		.pending       (pending),
		.checked       (checked),
		.text_seen     (text_seen),
		.pictures_seen (pictures_seen),
		.audio_seen    (audio_seen)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("tb: errors");
		$finish;
	end

	always @(posedge clk) begin
		res_ch.ready <= $urandom_range(99) >= take_idle;
	end

	// one request per byte, holding valid until it is taken
	task automatic send_byte(input logic [7:0] d, input logic fs, input logic fe);
		while ($urandom_range(99) < send_idle) begin
			bytes_ch.valid <= 1'b0;
			@(posedge clk);
		end
		bytes_ch.valid <= 1'b1;
		bytes_ch.data_byte <= d;
		bytes_ch.file_start <= fs;
		bytes_ch.file_end <= fe;
		@(posedge clk);
		while (!bytes_ch.ready)
			@(posedge clk);
		bytes_sent++;
	endtask

	task automatic send_file(input bit with_end, input int tail);
		for (int i = 0; i < file_q.size(); i++)
			send_byte(file_q[i], i == 0, with_end && i == file_q.size() - 1);
		repeat (tail)
			send_byte(8'($urandom), 1'b0, 1'($urandom_range(3) == 0));
		files_sent++;
	endtask

	task automatic drain_results();
		bytes_ch.valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		@(posedge clk);
	endtask

	function automatic void put_bytes(input int n);
		repeat (n)
			file_q.push_back(8'($urandom));
	endfunction

	function automatic void drop_tail(input int n);
		repeat (n)
			void'(file_q.pop_back());
	endfunction

	function automatic void put_size(input bit ss, input logic [31:0] v);
		if (ss) begin
			file_q.push_back({1'b0, v[27:21]});
			file_q.push_back({1'b0, v[20:14]});
			file_q.push_back({1'b0, v[13:7]});
			file_q.push_back({1'b0, v[6:0]});
		end else begin
			for (int k = 3; k >= 0; k--)
				file_q.push_back(v[8*k +: 8]);
		end
	endfunction

	function automatic void begin_tag(input logic [7:0] ver, input logic [7:0] flags);
		file_q.delete();
		for (int k = 2; k >= 0; k--)
			file_q.push_back(TAG_MAGIC[8*k +: 8]);
		file_q.push_back(ver);
		file_q.push_back(8'($urandom));
		file_q.push_back(flags);
		repeat (4)
			file_q.push_back(8'd0);
	endfunction

	// size is patched in once the body is known; delta makes it lie
	function automatic void end_tag(input int pad, input int delta);
		int sz;
		repeat (pad)
			file_q.push_back(8'd0);
		sz = file_q.size() - 10 + delta;
		if (sz < 0)
			sz = 0;
		file_q[6] = {1'b0, sz[27:21]};
		file_q[7] = {1'b0, sz[20:14]};
		file_q[8] = {1'b0, sz[13:7]};
		file_q[9] = {1'b0, sz[6:0]};
	endfunction

	function automatic void put_frame(input logic [31:0] id, input bit ss,
		input logic [31:0] size);
		for (int k = 3; k >= 0; k--)
			file_q.push_back(id[8*k +: 8]);
		put_size(ss, size);
		put_bytes(2);
	endfunction

	function automatic void put_text(input logic [31:0] id, input bit ss, input logic [7:0] enc,
		input int len, input bit term, input int extra);
		put_frame(id, ss, 32'(1 + len + term + extra));
		file_q.push_back(enc);
		repeat (len)
			file_q.push_back(8'($urandom_range(1, 255)));
		if (term)
			file_q.push_back(8'd0);
		put_bytes(extra);
	endfunction

	task automatic send_random_file();
		int          n, nfr, prefix;
		bit          ss, ext;
		logic [7:0]  ver, enc;
		logic [31:0] psz, other_id;
		if ($urandom_range(99) < 12) begin
			// missing or broken tag header
			file_q.delete();
			prefix = $urandom_range(0, 3);
			for (int k = 0; k < prefix; k++)
				file_q.push_back(TAG_MAGIC[8*(2 - k) +: 8]);
			put_bytes($urandom_range(1, 10));
		end else begin
			ver = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(2, 4));
			ss = ver >= 8'd4;
			ext = $urandom_range(3) == 0;
			begin_tag(ver, (8'($urandom) & ~FLAG_EXT) | (ext ? FLAG_EXT : 8'd0));
			if (ext) begin
				n = $urandom_range(0, 5);
				if (ss)
					put_size(1'b1, ($urandom_range(4) == 0) ?
						32'($urandom_range(0, 3)) : 32'(n + 4));
				else
					put_size(1'b0, 32'(n));
				put_bytes(n);
			end
			nfr = $urandom_range(0, 4);
			repeat (nfr) begin
				case ($urandom_range(4))
					0, 1: begin
						enc = ($urandom_range(3) == 0) ? 8'($urandom) :
							($urandom_range(1) ? ENC_UTF8 : ENC_LATIN1);
						put_text($urandom_range(1) ? ID_ARTIST : ID_TITLE, ss, enc,
							$urandom_range(0, 14), 1'($urandom_range(1)), $urandom_range(0, 2));
					end
					2: begin
						psz = ($urandom_range(5) == 0) ? $urandom : $urandom_range(1, 8);
						put_frame(ID_PICTURE, ss, psz);
						put_bytes((psz > 8) ? $urandom_range(0, 8) : int'(psz));
					end
					default: begin
						other_id = {8'($urandom_range(65, 90)), 8'($urandom_range(65, 90)),
							8'($urandom_range(65, 90)), 8'($urandom_range(48, 90))};
						n = $urandom_range(0, 6);
						put_frame(other_id, ss, 32'(n));
						put_bytes(n);
					end
				endcase
			end
			end_tag($urandom_range(0, 12),
				($urandom_range(3) == 0) ? $urandom_range(0, 24) - 12 : 0);
			put_bytes($urandom_range(0, 5));
		end
		if ($urandom_range(6) == 0 && file_q.size() > 1)
			drop_tail($urandom_range(1, file_q.size() - 1));
		send_file($urandom_range(7) != 0, ($urandom_range(9) == 0) ? $urandom_range(1, 4) : 0);
	endtask

	initial begin
		arst_n = 1'b0;
		bytes_ch.valid = 1'b0;
		bytes_ch.data_byte = 8'd0;
		bytes_ch.file_start = 1'b0;
		bytes_ch.file_end = 1'b0;
		res_ch.ready = 1'b0;
		send_idle = 29;
		take_idle = 52;
		files_sent = 0;
		bytes_sent = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// no tag: bad first, second and third magic byte
		file_q = '{8'h00, 8'hff, 8'h49, 8'h44};
		send_file(1'b1, 0);
		file_q = '{TAG_MAGIC[23:16], 8'hff};
		send_file(1'b1, 0);
		file_q = '{TAG_MAGIC[23:16], TAG_MAGIC[15:8], 8'h80, 8'h7f};
		send_file(1'b1, 0);
		// file ends inside the header
		file_q = '{TAG_MAGIC[23:16], TAG_MAGIC[15:8], TAG_MAGIC[7:0], 8'd4};
		send_file(1'b1, 0);

		// v3 walk: text with and without terminator, picture, zero-size frame,
		// other encoding, encoding-only text frame, then padding
		begin_tag(8'd3, 8'h00);
		put_text(ID_TITLE, 1'b0, ENC_LATIN1, 3, 1'b1, 2);
		put_text(ID_ARTIST, 1'b0, ENC_UTF8, 4, 1'b0, 0);
		put_frame(ID_PICTURE, 1'b0, 32'd5);
		put_bytes(5);
		put_frame("TALB", 1'b0, 32'd0);
		put_text(ID_TITLE, 1'b0, 8'd1, 3, 1'b1, 0);
		put_text(ID_ARTIST, 1'b0, ENC_UTF8, 0, 1'b0, 0);
		end_tag(12, 0);
		put_bytes(4);
		send_file(1'b1, 3);

		// v4 with extended header, text past the length limit, frame cut at tag end
		begin_tag(8'd4, FLAG_EXT);
		put_size(1'b1, 32'd6);
		put_bytes(2);
		put_text(ID_TITLE, 1'b1, ENC_UTF8, ID3_TEXT_MAX + 1, 1'b1, 0);
		put_text(ID_ARTIST, 1'b1, ENC_LATIN1, 2, 1'b0, 0);
		put_frame(ID_PICTURE, 1'b1, 32'd50);
		put_bytes(4);
		end_tag(0, 0);
		put_bytes(3);
		send_file(1'b1, 0);

		// v4 extended size below four, text cut by the tag end
		begin_tag(8'd4, FLAG_EXT);
		put_size(1'b1, 32'd2);
		put_text(ID_ARTIST, 1'b1, ENC_LATIN1, 5, 1'b0, 0);
		end_tag(0, -2);
		put_bytes(3);
		send_file(1'b1, 0);

		// v3 extended header, huge picture size cut by the tag end
		begin_tag(8'd3, FLAG_EXT);
		put_size(1'b0, 32'd3);
		put_bytes(3);
		put_frame(ID_PICTURE, 1'b0, 32'hffff_ffff);
		put_bytes(3);
		end_tag(0, 0);
		send_file(1'b1, 0);

		// empty tag
		begin_tag(8'd2, 8'h00);
		end_tag(0, 0);
		put_bytes(3);
		send_file(1'b1, 0);

		// room left for no frame header
		begin_tag(8'd3, 8'h00);
		put_text(ID_TITLE, 1'b0, ENC_LATIN1, 2, 1'b1, 0);
		end_tag(6, 0);
		send_file(1'b1, 0);

		// file ends in the middle of text
		begin_tag(8'd3, 8'h00);
		put_text(ID_TITLE, 1'b0, ENC_LATIN1, 6, 1'b1, 0);
		end_tag(0, 0);
		drop_tail(3);
		send_file(1'b1, 0);

		// restart by a new file before the end of this one
		begin_tag(8'd4, 8'h00);
		put_text(ID_ARTIST, 1'b1, ENC_UTF8, 4, 1'b0, 0);
		end_tag(0, 0);
		drop_tail(4);
		send_file(1'b0, 0);

		// largest tag size, cut short by the file end
		begin_tag(8'hff, 8'h00);
		for (int k = 6; k < 10; k++)
			file_q[k] = 8'h7f;
		put_bytes(3);
		send_file(1'b1, 0);

		drain_results();
		directed_bytes = bytes_sent;

		while (bytes_sent - directed_bytes < RANDOM_BYTES) begin
			if (bytes_sent - directed_bytes >= 2 * RANDOM_BYTES / 3) begin
				send_idle = 0;
				take_idle = 0;
			end else if (bytes_sent - directed_bytes >= RANDOM_BYTES / 3) begin
				send_idle = 52;
				take_idle = 29;
			end
			send_random_file();
		end

		drain_results();
		repeat (20) @(negedge clk);
		$display("summary: %0d files, %0d bytes (%0d directed), %0d results checked",
			files_sent, bytes_sent, directed_bytes, checked);
		$display("summary: %0d text results, %0d pictures, %0d audio starts, %0d failures",
			text_seen, pictures_seen, audio_seen, fail_count);
		if (fail_count == 0 && pending == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

endmodule

// File: files.f
rtl/core/id3_pkg.sv
rtl/core/id3_if.sv
rtl/core/id3_step.sv
rtl/core/id3_res_q.sv
rtl/core/id3v2_tag_frame_parser_unit.sv
rtl/core/id3_chk.sv
verif/id3_tb_pkg.sv
verif/id3_parse_checker.sv
verif/tb.sv
